>>> design/double_ended_queue_core_assert.svh
// assertion macros for the deque core
`ifndef DOUBLE_ENDED_QUEUE_CORE_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define DQ_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("deque core check failed");

// next-cycle implication
`define DQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("deque core check failed");

`else

`define DQ_ASSERT_NOW(label, clk, rst, ante, cons)
`define DQ_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

>>> design/dq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dq_pkg;

  // default configuration
  localparam int DEPTH_DEFAULT      = 32;
  localparam int VALUE_BITS_DEFAULT = 32;

  // fixed field widths
  localparam int ACTION_BITS = 3;
  localparam int STATUS_BITS = 2;
  localparam int ENTRY_BITS  = 32;
  localparam int EXT_BITS    = 64;

  // requested operation of an input beat
  typedef enum logic [ACTION_BITS-1:0] {
    ACT_PUSH_FRONT = 3'd0,
    ACT_PUSH_REAR  = 3'd1,
    ACT_POP_FRONT  = 3'd2,
    ACT_POP_REAR   = 3'd3,
    ACT_DUMP       = 3'd4
  } action_t;

  // result status codes
  typedef enum logic [STATUS_BITS-1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_t;

  // controller states
  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_POP_WAIT,
    S_DUMP
  } state_t;

  // controller to datapath commands
  typedef struct packed {
    logic    load_item;
    logic    push_front;
    logic    push_rear;
    logic    pop_front;
    logic    pop_rear;
    logic    dump_start;
    logic    dump_next;
    logic    out_load;
    status_t out_status;
    logic    out_from_mem;
    logic    out_final;
  } dq_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic [ACTION_BITS-1:0] action;
    logic                   empty;
    logic                   full;
    logic                   dump_last;
    logic                   out_free;
  } dq_stat_t;

endpackage

`default_nettype wire

>>> design/dq_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module dq_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_stall,
  input  dq_pkg::dq_stat_t stat,
  output dq_pkg::dq_cmd_t  cmd
);

  import dq_pkg::*;

  state_t state;
  state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (item_valid) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        unique case (stat.action) inside
          ACT_PUSH_FRONT, ACT_PUSH_REAR: begin
            if (stat.out_free) begin
              state_next = S_IDLE;
            end
          end
          ACT_POP_FRONT, ACT_POP_REAR: begin
            if (!stat.empty) begin
              state_next = S_POP_WAIT;
            end else if (stat.out_free) begin
              state_next = S_IDLE;
            end
          end
          ACT_DUMP: begin
            if (!stat.empty) begin
              state_next = S_DUMP;
            end else if (stat.out_free) begin
              state_next = S_IDLE;
            end
          end
          default: begin
            // unused codes give no result
            state_next = S_IDLE;
          end
        endcase
      end
      S_POP_WAIT: begin
        if (stat.out_free) begin
          state_next = S_IDLE;
        end
      end
      S_DUMP: begin
        if (stat.out_free && stat.dump_last) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // command outputs
  always_comb begin
    cmd              = '0;
    cmd.out_status   = STAT_OK;
    item_stall       = (state != S_IDLE);
    unique case (state)
      S_IDLE: begin
        cmd.load_item = item_valid;
      end
      S_EXEC: begin
        unique case (stat.action) inside
          ACT_PUSH_FRONT, ACT_PUSH_REAR: begin
            cmd.out_load   = stat.out_free;
            cmd.out_final  = 1'b1;
            cmd.out_status = stat.full ? STAT_FULL : STAT_OK;
            if (stat.out_free && !stat.full) begin
              cmd.push_front = (stat.action == ACT_PUSH_FRONT);
              cmd.push_rear  = (stat.action == ACT_PUSH_REAR);
            end
          end
          ACT_POP_FRONT, ACT_POP_REAR: begin
            if (stat.empty) begin
              cmd.out_load   = stat.out_free;
              cmd.out_final  = 1'b1;
              cmd.out_status = STAT_EMPTY;
            end else begin
              cmd.pop_front = (stat.action == ACT_POP_FRONT);
              cmd.pop_rear  = (stat.action == ACT_POP_REAR);
            end
          end
          ACT_DUMP: begin
            if (stat.empty) begin
              cmd.out_load   = stat.out_free;
              cmd.out_final  = 1'b1;
              cmd.out_status = STAT_EMPTY;
            end else begin
              cmd.dump_start = 1'b1;
            end
          end
          default: begin
            cmd.out_load = 1'b0;
          end
        endcase
      end
      S_POP_WAIT: begin
        cmd.out_load     = stat.out_free;
        cmd.out_from_mem = 1'b1;
        cmd.out_final    = 1'b1;
      end
      S_DUMP: begin
        cmd.out_load     = stat.out_free;
        cmd.out_from_mem = 1'b1;
        cmd.out_final    = stat.dump_last;
        cmd.dump_next    = stat.out_free && !stat.dump_last;
      end
      default: begin
        cmd.out_load = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> design/dq_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
`include "double_ended_queue_core_assert.svh"

module dq_datapath #(
  parameter int DEPTH      = dq_pkg::DEPTH_DEFAULT,
  parameter int VALUE_BITS = dq_pkg::VALUE_BITS_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  dq_pkg::dq_cmd_t                     cmd,
  output dq_pkg::dq_stat_t                    stat,
  input  logic [dq_pkg::ACTION_BITS-1:0]      action,
  input  logic signed [dq_pkg::ENTRY_BITS-1:0] value,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [dq_pkg::STATUS_BITS-1:0]      status,
  output logic signed [dq_pkg::ENTRY_BITS-1:0] entry,
  output logic                                final_res
);

  import dq_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int SUM_W = PTR_W + 1;

  // ring position arithmetic
  function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] pos);
    ring_next = (pos == PTR_W'(DEPTH - 1)) ? '0 : pos + PTR_W'(1);
  endfunction

  function automatic logic [PTR_W-1:0] ring_prev(input logic [PTR_W-1:0] pos);
    ring_prev = (pos == '0) ? PTR_W'(DEPTH - 1) : pos - PTR_W'(1);
  endfunction

  // off is at most DEPTH wherever the result is used, so one conditional subtract wraps the sum
  function automatic logic [PTR_W-1:0] ring_add(input logic [PTR_W-1:0] pos,
                                                 input logic [CNT_W-1:0] off);
    logic [SUM_W-1:0] s;
    s = SUM_W'(pos) + SUM_W'(off);
    if (s >= SUM_W'(DEPTH)) begin
      s = s - SUM_W'(DEPTH);
    end
    ring_add = s[PTR_W-1:0];
  endfunction

  // item registers
  logic [ACTION_BITS-1:0] item_action;
  logic [VALUE_BITS-1:0]  item_value;
  logic [EXT_BITS-1:0]    value_ext;

  // queue pointers
  logic [PTR_W-1:0] front;
  logic [CNT_W-1:0] occupancy;
  logic [PTR_W-1:0] dump_pos;
  logic [CNT_W-1:0] dump_left;

  // slot store
  logic [VALUE_BITS-1:0] mem [DEPTH];
  logic [VALUE_BITS-1:0] rdata;
  logic [EXT_BITS-1:0]   rdata_ext;
  logic                  rd_en;
  logic [PTR_W-1:0]      rd_addr;
  logic                  wr_en;
  logic [PTR_W-1:0]      wr_addr;
  logic [PTR_W-1:0]      rear_pos;
  logic [PTR_W-1:0]      tail_pos;

  assign value_ext = EXT_BITS'($unsigned(value));
  assign rdata_ext = EXT_BITS'(rdata);

  // latch accepted beat
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_action <= action;
      item_value  <= value_ext[VALUE_BITS-1:0];
    end
  end

  // slot addresses
  assign rear_pos = ring_add(front, occupancy - CNT_W'(1));
  assign tail_pos = ring_add(front, occupancy);

  always_comb begin
    rd_en   = cmd.pop_front | cmd.pop_rear | cmd.dump_start | cmd.dump_next;
    rd_addr = front;
    if (cmd.pop_rear) begin
      rd_addr = rear_pos;
    end else if (cmd.dump_next) begin
      rd_addr = ring_next(dump_pos);
    end
    wr_en   = cmd.push_front | cmd.push_rear;
    wr_addr = cmd.push_front ? ring_prev(front) : tail_pos;
  end

  // memory write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= item_value;
    end
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  // front and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      front     <= '0;
      occupancy <= '0;
    end else begin
      if (cmd.push_front) begin
        front <= ring_prev(front);
      end else if (cmd.pop_front) begin
        front <= ring_next(front);
      end
      if (cmd.push_front || cmd.push_rear) begin
        occupancy <= occupancy + CNT_W'(1);
      end else if (cmd.pop_front || cmd.pop_rear) begin
        occupancy <= occupancy - CNT_W'(1);
      end
    end
  end

  // dump walk
  always_ff @(posedge clk) begin
    if (rst) begin
      dump_pos  <= '0;
      dump_left <= '0;
    end else if (cmd.dump_start) begin
      dump_pos  <= front;
      dump_left <= occupancy;
    end else if (cmd.dump_next) begin
      dump_pos  <= ring_next(dump_pos);
      dump_left <= dump_left - CNT_W'(1);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      status    <= cmd.out_status;
      entry     <= cmd.out_from_mem ? rdata_ext[ENTRY_BITS-1:0] : '0;
      final_res <= cmd.out_final;
    end
  end

  // status to controller
  always_comb begin
    stat.action    = item_action;
    stat.empty     = (occupancy == '0);
    stat.full      = (occupancy == CNT_W'(DEPTH));
    stat.dump_last = (dump_left == CNT_W'(1));
    stat.out_free  = !out_valid || !out_stall;
  end

  // checks
  `DQ_ASSERT_NOW(a_occ_bound, clk, rst, 1'b1, occupancy <= CNT_W'(DEPTH))
  `DQ_ASSERT_NOW(a_no_overwrite, clk, rst, cmd.out_load, !out_valid || !out_stall)
  `DQ_ASSERT_NOW(a_pop_nonempty, clk, rst, rd_en && !cmd.dump_next, occupancy != '0)
  `DQ_ASSERT_NOW(a_push_room, clk, rst, wr_en, occupancy != CNT_W'(DEPTH))
  `DQ_ASSERT_NEXT(a_dump_count, clk, rst, cmd.dump_start, dump_left != '0)

endmodule

`default_nettype wire

>>> design/double_ended_queue_core.sv
// Bounded double-ended queue over a ring of DEPTH slots.
// Input channel (item_valid / item_stall) carries one action and a value;
// actions: push front, push rear, pop front, pop rear, dump all.
// Output channel (result_valid / result_stall) carries status, entry and
// final_res; final_res marks the last result beat of each input beat.
// An input beat is taken only while the controller is idle. A push or an
// empty/full answer is decided in the execute state after acceptance and
// loaded into the output register from that state. A pop reads the slot
// memory through its registered read port in the execute state and loads
// its result from the read data in a wait state. A dump streams one result
// per cycle while the result is not stalled, after a start read in the
// execute state. Unused action codes give no result.
// A stalled result holds in the output register and the controller waits;
// no new input beat is taken until the pending work is done.
// Reset clears the front position, the count and all handshake state; the
// slot contents are not cleared, only written slots are ever read.
`timescale 1ns / 1ps
`default_nettype none

module double_ended_queue_core #(
  parameter int DEPTH      = dq_pkg::DEPTH_DEFAULT,
  parameter int VALUE_BITS = dq_pkg::VALUE_BITS_DEFAULT
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 item_valid,
  output logic                                 item_stall,
  input  logic [dq_pkg::ACTION_BITS-1:0]       action,
  input  logic signed [dq_pkg::ENTRY_BITS-1:0] value,
  output logic                                 result_valid,
  input  logic                                 result_stall,
  output logic [dq_pkg::STATUS_BITS-1:0]       status,
  output logic signed [dq_pkg::ENTRY_BITS-1:0] entry,
  output logic                                 final_res
);

  import dq_pkg::*;

  dq_cmd_t  cmd;
  dq_stat_t stat;

  // sequencer
  dq_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .stat       (stat),
    .cmd        (cmd)
  );

  // storage, pointers and output register
  dq_datapath #(
    .DEPTH      (DEPTH),
    .VALUE_BITS (VALUE_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .action    (action),
    .value     (value),
    .out_valid (result_valid),
    .out_stall (result_stall),
    .status    (status),
    .entry     (entry),
    .final_res (final_res)
  );

endmodule

`default_nettype wire
